// File: sv/spc_pkg.sv
// Shared constants and codes for the segment pair closest point block.
// No dependencies; the files that use it refer to it by scoped names.
package spc_pkg;

  // Result field widths, fixed by the result format
  localparam int unsigned PARAM_W = 17;
  localparam int unsigned POINT_W = 32;
  localparam int unsigned DIST_W  = 50;

  // Number of projection lanes and depth of the front-to-back queue
  localparam int unsigned LANES       = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Saturation value of the squared distance
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Endpoint candidates of the parallel case, in priority order
  typedef enum logic [1:0] {
    CAND_A_START,
    CAND_A_END,
    CAND_B_START,
    CAND_B_END
  } cand_e;

endpackage

// File: sv/spc_if.sv
// Valid/ready channel interfaces for segment pairs and closest point results.
// Depends on spc_pkg for the result field widths.
interface spc_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_start_z;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] a_end_z;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_start_z;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;
  logic signed [COORD_BITS-1:0] b_end_z;

  modport source (
    output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
           b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
           b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
    output ready
  );
endinterface

interface spc_out_if ();
  logic                                valid;
  logic                                ready;
  logic        [spc_pkg::PARAM_W-1:0]  param_a;
  logic        [spc_pkg::PARAM_W-1:0]  param_b;
  logic signed [spc_pkg::POINT_W-1:0]  near_a_x;
  logic signed [spc_pkg::POINT_W-1:0]  near_a_y;
  logic signed [spc_pkg::POINT_W-1:0]  near_a_z;
  logic signed [spc_pkg::POINT_W-1:0]  near_b_x;
  logic signed [spc_pkg::POINT_W-1:0]  near_b_y;
  logic signed [spc_pkg::POINT_W-1:0]  near_b_z;
  logic        [spc_pkg::DIST_W-1:0]   dist_squared;

  modport source (
    output valid, param_a, param_b, near_a_x, near_a_y, near_a_z,
           near_b_x, near_b_y, near_b_z, dist_squared,
    input  ready
  );
  modport sink (
    input  valid, param_a, param_b, near_a_x, near_a_y, near_a_z,
           near_b_x, near_b_y, near_b_z, dist_squared,
    output ready
  );
endinterface

// File: sv/spc_front.sv
// Front pipeline: dot products, determinant, edge clamping and classification.
// Depends on spc_in_if; emits four numerator/denominator pairs per segment pair.
module spc_front #(
  parameter  int CW = 16,
  localparam int DW = CW + 1,
  localparam int PW = 2 * DW + 2,
  localparam int NW = 2 * PW + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  spc_in_if.sink                         in_i,
  output logic                           job_valid_o,
  input  logic                           job_ready_i,
  output logic                           job_par_o,
  output logic [3:0][NW-1:0]             job_num_o,
  output logic [3:0][NW-1:0]             job_den_o,
  output logic [3:0][2:0][CW-1:0]        job_pts_o
);

  localparam int IA = 0;
  localparam int IB = 1;
  localparam int IC = 2;
  localparam int ID = 3;
  localparam int IE = 4;

  logic                    en;
  logic [6:1]              vld_q;
  logic [3:0][2:0][CW-1:0] pts_in;
  logic [3:0][2:0][CW-1:0] pts_q [1:6];

  logic signed [DW-1:0]    du_d [3];
  logic signed [DW-1:0]    dv_d [3];
  logic signed [DW-1:0]    dw_d [3];
  logic signed [DW-1:0]    du_q [3];
  logic signed [DW-1:0]    dv_q [3];
  logic signed [DW-1:0]    dw_q [3];

  logic signed [PW-1:0]    dot_d [5];
  logic signed [PW-1:0]    dot_q [2:5][5];

  logic signed [2*PW-1:0]  prod_d [6];
  logic signed [2*PW-1:0]  prod_q [6];

  logic signed [NW-1:0]    dd4_d, sn4_d, tn4_d;
  logic signed [NW-1:0]    dd4_q, sn4_q, tn4_q;

  logic                    par5_d, par5_q;
  logic signed [NW-1:0]    sn5_d, tn5_d, td5_d, sd5_d;
  logic signed [NW-1:0]    sn5_q, tn5_q, td5_q, sd5_q;

  logic                    par6_q;
  logic [3:0][NW-1:0]      num6_d, den6_d;
  logic [3:0][NW-1:0]      num6_q, den6_q;

  // Advance unless the last stage holds a job the queue refuses
  assign en         = !vld_q[6] || job_ready_i;
  assign in_i.ready = en;

  // Gather endpoints: 0 A start, 1 A end, 2 B start, 3 B end
  always_comb begin
    pts_in[0] = {in_i.a_start_z, in_i.a_start_y, in_i.a_start_x};
    pts_in[1] = {in_i.a_end_z,   in_i.a_end_y,   in_i.a_end_x};
    pts_in[2] = {in_i.b_start_z, in_i.b_start_y, in_i.b_start_x};
    pts_in[3] = {in_i.b_end_z,   in_i.b_end_y,   in_i.b_end_x};
  end

  // Direction vectors u, v and offset w
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      du_d[k] = DW'($signed(pts_in[1][k])) - DW'($signed(pts_in[0][k]));
      dv_d[k] = DW'($signed(pts_in[3][k])) - DW'($signed(pts_in[2][k]));
      dw_d[k] = DW'($signed(pts_in[0][k])) - DW'($signed(pts_in[2][k]));
    end
  end

  // Dot products a = u.u, b = u.v, c = v.v, d = u.w, e = v.w
  always_comb begin
    logic signed [PW-1:0] ue [3];
    logic signed [PW-1:0] ve [3];
    logic signed [PW-1:0] we [3];
    for (int k = 0; k < 3; k++) begin
      ue[k] = PW'(du_q[k]);
      ve[k] = PW'(dv_q[k]);
      we[k] = PW'(dw_q[k]);
    end
    dot_d[IA] = ue[0] * ue[0] + ue[1] * ue[1] + ue[2] * ue[2];
    dot_d[IB] = ue[0] * ve[0] + ue[1] * ve[1] + ue[2] * ve[2];
    dot_d[IC] = ve[0] * ve[0] + ve[1] * ve[1] + ve[2] * ve[2];
    dot_d[ID] = ue[0] * we[0] + ue[1] * we[1] + ue[2] * we[2];
    dot_d[IE] = ve[0] * we[0] + ve[1] * we[1] + ve[2] * we[2];
  end

  // Cross products for the determinant and both numerators
  always_comb begin
    logic signed [2*PW-1:0] xa, xb, xc, xd, xe;
    xa = (2*PW)'(dot_q[2][IA]);
    xb = (2*PW)'(dot_q[2][IB]);
    xc = (2*PW)'(dot_q[2][IC]);
    xd = (2*PW)'(dot_q[2][ID]);
    xe = (2*PW)'(dot_q[2][IE]);
    prod_d[0] = xa * xc;
    prod_d[1] = xb * xb;
    prod_d[2] = xb * xe;
    prod_d[3] = xc * xd;
    prod_d[4] = xa * xe;
    prod_d[5] = xb * xd;
  end

  // D = ac - bb, sN = be - cd, tN = ae - bd
  always_comb begin
    dd4_d = NW'(prod_q[0]) - NW'(prod_q[1]);
    sn4_d = NW'(prod_q[2]) - NW'(prod_q[3]);
    tn4_d = NW'(prod_q[4]) - NW'(prod_q[5]);
  end

  // Classify and clamp the first parameter to its edges
  always_comb begin
    logic signed [NW-1:0] b4, c4, e4;
    b4     = NW'(dot_q[4][IB]);
    c4     = NW'(dot_q[4][IC]);
    e4     = NW'(dot_q[4][IE]);
    par5_d = dd4_q[NW-1] || (dd4_q == '0);
    sn5_d  = sn4_q;
    tn5_d  = tn4_q;
    td5_d  = dd4_q;
    sd5_d  = dd4_q;
    if (sn4_q[NW-1]) begin
      sn5_d = '0;
      tn5_d = e4;
      td5_d = c4;
    end else if (sn4_q > dd4_q) begin
      sn5_d = dd4_q;
      tn5_d = e4 + b4;
      td5_d = c4;
    end
  end

  // Clamp the second parameter, re-solve the first, build the lane jobs
  always_comb begin
    logic signed [NW-1:0] a5, b5, c5, d5, e5, k5, s5, sd5, t5;
    logic                 tneg;
    a5   = NW'(dot_q[5][IA]);
    b5   = NW'(dot_q[5][IB]);
    c5   = NW'(dot_q[5][IC]);
    d5   = NW'(dot_q[5][ID]);
    e5   = NW'(dot_q[5][IE]);
    s5   = sn5_q;
    sd5  = sd5_q;
    t5   = tn5_q;
    tneg = tn5_q[NW-1];
    k5   = tneg ? -d5 : b5 - d5;
    if (tneg || (tn5_q > td5_q)) begin
      t5 = tneg ? '0 : td5_q;
      if (k5[NW-1]) begin
        s5 = '0;
      end else if (k5 > a5) begin
        s5 = sd5_q;
      end else begin
        s5  = k5;
        sd5 = a5;
      end
    end
    // Lanes 0 and 1 carry the two line parameters when not parallel
    num6_d[0] = par5_q ? e5      : s5;
    den6_d[0] = par5_q ? c5      : sd5;
    num6_d[1] = par5_q ? e5 + b5 : t5;
    den6_d[1] = par5_q ? c5      : td5_q;
    num6_d[2] = -d5;
    den6_d[2] = a5;
    num6_d[3] = b5 - d5;
    den6_d[3] = a5;
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:1], in_i.valid};
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (en) begin
      pts_q[1] <= pts_in;
      for (int s = 2; s <= 6; s++) begin
        pts_q[s] <= pts_q[s-1];
      end
      du_q     <= du_d;
      dv_q     <= dv_d;
      dw_q     <= dw_d;
      dot_q[2] <= dot_d;
      dot_q[3] <= dot_q[2];
      dot_q[4] <= dot_q[3];
      dot_q[5] <= dot_q[4];
      prod_q   <= prod_d;
      dd4_q    <= dd4_d;
      sn4_q    <= sn4_d;
      tn4_q    <= tn4_d;
      par5_q   <= par5_d;
      sn5_q    <= sn5_d;
      tn5_q    <= tn5_d;
      td5_q    <= td5_d;
      sd5_q    <= sd5_d;
      par6_q   <= par5_q;
      num6_q   <= num6_d;
      den6_q   <= den6_d;
    end
  end

  assign job_valid_o = vld_q[6];
  assign job_par_o   = par6_q;
  assign job_num_o   = num6_q;
  assign job_den_o   = den6_q;
  assign job_pts_o   = pts_q[6];

endmodule

// File: sv/spc_queue.sv
// Short FIFO between the front and back pipelines.
// Depends on spc_pkg for its depth; the entry type is a module parameter.
module spc_queue #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  T     push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output T     pop_data_o
);

  localparam int DEPTH = spc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                   mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");

  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count missed a pop");

  a_head_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && cnt_q == '0) |=> pop_data_o == $past(push_data_i))
    else $error("queue head differs from first entry written");

endmodule

// File: sv/spc_ratio.sv
// Pipelined restoring divider: round(n * 2^F / d), clamped to [0, 1].
// No dependencies; one quotient bit per stage.
module spc_ratio #(
  parameter int NW = 73,
  parameter int F  = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [NW-1:0] den_i,
  output logic [F:0]           q_o
);

  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic [NW:0]  rem_q  [F+1];
  logic [NW:0]  dv_q   [F+1];
  logic [F-1:0] qb_q   [F+1];
  logic         zero_q [F+1];
  logic         one_q  [F+1];
  logic [NW:0]  rem_d  [1:F];
  logic         ge_d   [1:F];
  logic [NW:0]  rr;
  logic         up;

  // One trial subtract per stage
  always_comb begin
    logic [NW:0] r2;
    for (int k = 1; k <= F; k++) begin
      r2       = rem_q[k-1] << 1;
      ge_d[k]  = (r2 >= dv_q[k-1]);
      rem_d[k] = ge_d[k] ? r2 - dv_q[k-1] : r2;
    end
  end

  // Round half up from the final remainder
  assign rr = rem_q[F] << 1;
  assign up = (rr >= dv_q[F]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Flag the trivial outcomes at entry
      zero_q[0] <= num_i[NW-1] || (num_i == '0) || den_i[NW-1] || (den_i == '0);
      one_q[0]  <= (num_i >= den_i);
      rem_q[0]  <= {1'b0, num_i};
      dv_q[0]   <= {1'b0, den_i};
      qb_q[0]   <= '0;
      for (int k = 1; k <= F; k++) begin
        zero_q[k] <= zero_q[k-1];
        one_q[k]  <= one_q[k-1];
        rem_q[k]  <= rem_d[k];
        dv_q[k]   <= dv_q[k-1];
        qb_q[k]   <= {qb_q[k-1][F-2:0], ge_d[k]};
      end
      if (zero_q[F]) begin
        q_o <= '0;
      end else if (one_q[F]) begin
        q_o <= ONE;
      end else begin
        q_o <= {1'b0, qb_q[F]} + (F+1)'(up);
      end
    end
  end

endmodule

// File: sv/spc_back.sv
// Back pipeline: four divider lanes, closest points, distances, selection.
// Depends on spc_pkg, spc_out_if and spc_ratio.
module spc_back #(
  parameter  int CW  = 16,
  parameter  int F   = 16,
  localparam int DW  = CW + 1,
  localparam int PW  = 2 * DW + 2,
  localparam int NW  = 2 * PW + 1,
  localparam int L   = F + 2,
  localparam int PTW = CW + F + 1,
  localparam int DFW = PTW + 1,
  localparam int SQW = 2 * DFW,
  localparam int DSW = SQW + 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  logic                    job_par_i,
  input  logic [3:0][NW-1:0]      job_num_i,
  input  logic [3:0][NW-1:0]      job_den_i,
  input  logic [3:0][2:0][CW-1:0] job_pts_i,
  spc_out_if.source               out_o
);

  localparam int         RW  = (DSW + 1 > spc_pkg::DIST_W + 1) ? DSW + 1
                                                                : spc_pkg::DIST_W + 1;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  typedef logic [3:0][2:0][CW-1:0] pts_t;

  logic                    en;
  logic [L-1:0]            vd_q;
  logic                    vp_q, vs_q, vm_q, vw_q, vo_q;
  logic                    cpar_q [L];
  pts_t                    cpts_q [L];
  logic [F:0]              tq     [4];

  // Point stage
  logic signed [PTW-1:0]   pp_d [4][3];
  logic signed [PTW-1:0]   pp_q [4][3];
  logic                    parp_q;
  pts_t                    ptsp_q;
  logic [F:0]              tp_q [4];

  // Square stage
  logic [SQW-1:0]          sq_d [4][3];
  logic [SQW-1:0]          sq_q [4][3];
  logic signed [PTW-1:0]   pps_q [4][3];
  logic                    pars_q;
  pts_t                    ptss_q;
  logic [F:0]              ts_q [4];

  // Sum stage
  logic [DSW-1:0]          sum_d [4];
  logic [DSW-1:0]          sum_q [4];
  logic signed [PTW-1:0]   ppm_q [4][3];
  logic                    parm_q;
  pts_t                    ptsm_q;
  logic [F:0]              tm_q [4];

  // Selection stage
  spc_pkg::cand_e          win;
  logic [F:0]              ta_d, tb_d, ta_q, tb_q;
  logic signed [PTW-1:0]   na_d [3];
  logic signed [PTW-1:0]   nb_d [3];
  logic signed [PTW-1:0]   na_q [3];
  logic signed [PTW-1:0]   nb_q [3];
  logic [DSW-1:0]          dist_d, dist_q;

  // Output register
  logic [DSW:0]                        rnd;
  logic [DSW:0]                        sh;
  logic                                sat;
  logic [spc_pkg::PARAM_W-1:0]         pa_q, pb_q;
  logic signed [spc_pkg::POINT_W-1:0]  oa_q [3];
  logic signed [spc_pkg::POINT_W-1:0]  ob_q [3];
  logic [spc_pkg::DIST_W-1:0]          od_q;

  // Hold the whole back pipeline while the result waits
  assign en          = !vo_q || out_o.ready;
  assign job_ready_o = en;

  // Divider lanes
  for (genvar i = 0; i < 4; i++) begin : g_lane
    spc_ratio #(
      .NW (NW),
      .F  (F)
    ) u_ratio (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ($signed(job_num_i[i])),
      .den_i ($signed(job_den_i[i])),
      .q_o   (tq[i])
    );
  end

  // Points: projected point per lane, start * 2^F + t * direction
  always_comb begin
    logic                  on_b;
    logic signed [PTW-1:0] base, dir;
    pts_t                  p;
    p = cpts_q[L-1];
    for (int i = 0; i < 4; i++) begin
      on_b = cpar_q[L-1] ? (i < 2) : (i == 1);
      for (int k = 0; k < 3; k++) begin
        base = on_b ? PTW'($signed(p[2][k])) : PTW'($signed(p[0][k]));
        dir  = (on_b ? PTW'($signed(p[3][k])) : PTW'($signed(p[1][k]))) - base;
        pp_d[i][k] = (base <<< F) + PTW'($signed({1'b0, tq[i]})) * dir;
      end
    end
  end

  // Squares: against the own endpoint when parallel, else point A minus point B
  always_comb begin
    logic signed [PTW-1:0] other;
    logic signed [SQW-1:0] df;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        other = parp_q ? (PTW'($signed(ptsp_q[i][k])) <<< F) : pp_q[1][k];
        df    = SQW'(DFW'(pp_q[i][k]) - DFW'(other));
        sq_d[i][k] = df * df;
      end
    end
  end

  // Sums of squares
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_d[i] = DSW'(sq_q[i][0]) + DSW'(sq_q[i][1]) + DSW'(sq_q[i][2]);
    end
  end

  // When parallel, select the nearest candidate, earliest on a tie; else lanes 0 and 1
  always_comb begin
    spc_pkg::cand_e w01, w23;
    logic [F:0]     ext;
    w01 = (sum_q[1] < sum_q[0]) ? spc_pkg::CAND_A_END : spc_pkg::CAND_A_START;
    w23 = (sum_q[3] < sum_q[2]) ? spc_pkg::CAND_B_END : spc_pkg::CAND_B_START;
    win = (sum_q[w23] < sum_q[w01]) ? w23 : w01;
    ext = (win == spc_pkg::CAND_A_END || win == spc_pkg::CAND_B_END) ? ONE : '0;
    ta_d   = tm_q[0];
    tb_d   = tm_q[1];
    dist_d = sum_q[0];
    for (int k = 0; k < 3; k++) begin
      na_d[k] = ppm_q[0][k];
      nb_d[k] = ppm_q[1][k];
    end
    if (parm_q) begin
      dist_d = sum_q[win];
      if (win inside {spc_pkg::CAND_A_START, spc_pkg::CAND_A_END}) begin
        ta_d = ext;
        tb_d = tm_q[win];
        for (int k = 0; k < 3; k++) begin
          na_d[k] = PTW'($signed(ptsm_q[win][k])) <<< F;
          nb_d[k] = ppm_q[win][k];
        end
      end else begin
        ta_d = tm_q[win];
        tb_d = ext;
        for (int k = 0; k < 3; k++) begin
          na_d[k] = ppm_q[win][k];
          nb_d[k] = PTW'($signed(ptsm_q[win][k])) <<< F;
        end
      end
    end
  end

  // Round the distance to F fraction bits and saturate
  assign rnd = {1'b0, dist_q} + ((DSW+1)'(1) << (F - 1));
  assign sh  = rnd >> F;
  assign sat = RW'(sh) > RW'(spc_pkg::DIST_MAX);

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= '0;
      vp_q <= 1'b0;
      vs_q <= 1'b0;
      vm_q <= 1'b0;
      vw_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      vd_q <= {vd_q[L-2:0], job_valid_i};
      vp_q <= vd_q[L-1];
      vs_q <= vp_q;
      vm_q <= vs_q;
      vw_q <= vm_q;
      vo_q <= vw_q;
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (en) begin
      cpar_q[0] <= job_par_i;
      cpts_q[0] <= job_pts_i;
      for (int s = 1; s < L; s++) begin
        cpar_q[s] <= cpar_q[s-1];
        cpts_q[s] <= cpts_q[s-1];
      end
      pp_q   <= pp_d;
      parp_q <= cpar_q[L-1];
      ptsp_q <= cpts_q[L-1];
      tp_q   <= tq;
      sq_q   <= sq_d;
      pps_q  <= pp_q;
      pars_q <= parp_q;
      ptss_q <= ptsp_q;
      ts_q   <= tp_q;
      sum_q  <= sum_d;
      ppm_q  <= pps_q;
      parm_q <= pars_q;
      ptsm_q <= ptss_q;
      tm_q   <= ts_q;
      ta_q   <= ta_d;
      tb_q   <= tb_d;
      na_q   <= na_d;
      nb_q   <= nb_d;
      dist_q <= dist_d;
      pa_q   <= spc_pkg::PARAM_W'(ta_q);
      pb_q   <= spc_pkg::PARAM_W'(tb_q);
      for (int k = 0; k < 3; k++) begin
        oa_q[k] <= spc_pkg::POINT_W'(na_q[k]);
        ob_q[k] <= spc_pkg::POINT_W'(nb_q[k]);
      end
      od_q <= sat ? spc_pkg::DIST_MAX : spc_pkg::DIST_W'(sh);
    end
  end

  assign out_o.valid        = vo_q;
  assign out_o.param_a      = pa_q;
  assign out_o.param_b      = pb_q;
  assign out_o.near_a_x     = oa_q[0];
  assign out_o.near_a_y     = oa_q[1];
  assign out_o.near_a_z     = oa_q[2];
  assign out_o.near_b_x     = ob_q[0];
  assign out_o.near_b_y     = ob_q[1];
  assign out_o.near_b_z     = ob_q[2];
  assign out_o.dist_squared = od_q;

endmodule

// File: sv/segment_pair_closest_points.sv
// Closest points between two 3D segments: one segment pair in, one result out.
//
// Input channel in_i carries both segments' endpoints as signed integers;
// output channel out_o carries the parameter on each segment (Q1.16), the
// two closest points (Q16.16) and the rounded squared distance (Q34.16).
// Both channels transfer on a clock edge with valid and ready high.
//
// Throughput: one pair per cycle while out_o does not stall. The path from
// input transfer to output valid runs through the six stage front pipeline,
// the queue, the FRAC_BITS + 2 stage divider lanes and five stages of point,
// square, sum, select and rounding.
//
// A four entry queue sits between front and back. When out_o stalls, the
// back pipeline holds in place and the front keeps accepting until the
// queue fills; in_i.ready then drops. Reset empties all pipelines and the
// queue; no result is pending after reset.
//
// Depends on spc_pkg, spc_if, spc_front, spc_queue, spc_ratio and spc_back.
module segment_pair_closest_points #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spc_in_if.sink     in_i,
  spc_out_if.source  out_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW + 2;
  localparam int NW = 2 * PW + 1;

  typedef struct packed {
    logic                            par;
    logic [3:0][NW-1:0]              num;
    logic [3:0][NW-1:0]              den;
    logic [3:0][2:0][COORD_BITS-1:0] pts;
  } job_t;

  job_t push_job, pop_job;
  logic push_valid, push_ready, pop_valid, pop_ready;
  logic                            f_par;
  logic [3:0][NW-1:0]              f_num, f_den;
  logic [3:0][2:0][COORD_BITS-1:0] f_pts;

  spc_front #(
    .CW (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_par_o   (f_par),
    .job_num_o   (f_num),
    .job_den_o   (f_den),
    .job_pts_o   (f_pts)
  );

  // Pack the classified job for the queue
  always_comb begin
    push_job.par = f_par;
    push_job.num = f_num;
    push_job.den = f_den;
    push_job.pts = f_pts;
  end

  spc_queue #(
    .T (job_t)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  spc_back #(
    .CW (COORD_BITS),
    .F  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_par_i   (pop_job.par),
    .job_num_i   (pop_job.num),
    .job_den_i   (pop_job.den),
    .job_pts_i   (pop_job.pts),
    .out_o       (out_o)
  );

endmodule

// File: bench/tb_segment_pair_closest_points.sv
// Self-checking testbench for segment_pair_closest_points: directed table, then random pairs.
// Depends on spc_pkg, the spc_in_if/spc_out_if interfaces and the block's RTL.
module tb_segment_pair_closest_points;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RANDOM   = 2000;
  localparam int unsigned STALL_MAX  = 5000;
  localparam int unsigned DRAIN_WAIT = 40;
  localparam logic [spc_pkg::PARAM_W-1:0] ONE_Q = 17'h10000;

  typedef logic signed [127:0] wide_t;
  typedef wide_t vec3_t [3];

  typedef struct {
    logic signed [15:0] c [12];
  } pair_t;

  typedef struct packed {
    logic [spc_pkg::PARAM_W-1:0] param_a;
    logic [spc_pkg::PARAM_W-1:0] param_b;
    logic [spc_pkg::POINT_W-1:0] near_a_x;
    logic [spc_pkg::POINT_W-1:0] near_a_y;
    logic [spc_pkg::POINT_W-1:0] near_a_z;
    logic [spc_pkg::POINT_W-1:0] near_b_x;
    logic [spc_pkg::POINT_W-1:0] near_b_y;
    logic [spc_pkg::POINT_W-1:0] near_b_z;
    logic [spc_pkg::DIST_W-1:0]  dist_squared;
  } closest_t;

  typedef struct {
    pair_t    p;
    bit       typed;
    closest_t r;
  } stim_t;

  logic clk_i;
  logic rst_ni;

  spc_in_if #(.COORD_BITS(16)) in_ch ();
  spc_out_if                   out_ch ();

  segment_pair_closest_points #(.COORD_BITS(16), .FRAC_BITS(16)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  stim_t       pair_q[$];
  closest_t    closest_q[$];
  closest_t    pending_closest;
  int unsigned n_total;
  int unsigned n_accepted;
  int unsigned n_errors;
  int unsigned stall_cnt;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Closest point predictor
  // ---------------------------------------------------------------------
  function automatic wide_t dot3(vec3_t x, vec3_t y);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  // round(n * 2^16 / d) to nearest, ties up, held within [0, 1]
  function automatic logic [spc_pkg::PARAM_W-1:0] ratio_q(wide_t n, wide_t d);
    wide_t sc, q, r;
    if (n <= 0 || d <= 0) return '0;
    if (n >= d) return ONE_Q;
    sc = n <<< 16;
    q  = sc / d;
    r  = sc % d;
    if (2 * r >= d) q = q + 1;
    return q[spc_pkg::PARAM_W-1:0];
  endfunction

  function automatic wide_t sq_dist(vec3_t p, vec3_t q);
    wide_t s;
    s = 0;
    for (int i = 0; i < 3; i++) s = s + (p[i] - q[i]) * (p[i] - q[i]);
    return s;
  endfunction

  // Project integer point x onto segment s..e; point comes back in Q.16
  function automatic wide_t project(vec3_t x, vec3_t s, vec3_t e,
                                    output logic [spc_pkg::PARAM_W-1:0] t,
                                    output vec3_t pt);
    vec3_t se, sx, xq;
    wide_t num, den;
    for (int i = 0; i < 3; i++) begin
      se[i] = e[i] - s[i];
      sx[i] = x[i] - s[i];
    end
    num = dot3(se, sx);
    den = dot3(se, se);
    if (num <= 0) t = '0;
    else if (num >= den) t = ONE_Q;
    else t = ratio_q(num, den);
    for (int i = 0; i < 3; i++) begin
      pt[i] = (s[i] <<< 16) + $signed({111'd0, t}) * se[i];
      xq[i] = x[i] <<< 16;
    end
    return sq_dist(pt, xq);
  endfunction

  function automatic closest_t predict_closest(pair_t p);
    vec3_t as, ae, bs, be, u, v, w, na, nb, pt, pnt, ss, es;
    wide_t a, b, c, d, e, dd, sn, tn, sd, td, k, best, dcur, rnd;
    logic [spc_pkg::PARAM_W-1:0] t1, t2, t;
    bit have;
    closest_t r;
    for (int i = 0; i < 3; i++) begin
      as[i] = 128'(p.c[i]);
      ae[i] = 128'(p.c[3 + i]);
      bs[i] = 128'(p.c[6 + i]);
      be[i] = 128'(p.c[9 + i]);
      u[i]  = ae[i] - as[i];
      v[i]  = be[i] - bs[i];
      w[i]  = as[i] - bs[i];
    end
    a = dot3(u, u); b = dot3(u, v); c = dot3(v, v);
    d = dot3(u, w); e = dot3(v, w);
    dd = a * c - b * b;
    t1 = '0; t2 = '0;
    if (dd <= 0) begin
      // Parallel: nearest of the four endpoint projections, first wins a tie
      have = 1'b0;
      best = 0;
      for (int i = 0; i < 3; i++) begin na[i] = 0; nb[i] = 0; end
      for (int n = 0; n < 4; n++) begin
        case (spc_pkg::cand_e'(n))
          spc_pkg::CAND_A_START: begin pnt = as; ss = bs; es = be; end
          spc_pkg::CAND_A_END:   begin pnt = ae; ss = bs; es = be; end
          spc_pkg::CAND_B_START: begin pnt = bs; ss = as; es = ae; end
          default:               begin pnt = be; ss = as; es = ae; end
        endcase
        dcur = project(pnt, ss, es, t, pt);
        if (!have || dcur < best) begin
          have = 1'b1;
          best = dcur;
          for (int j = 0; j < 3; j++) begin
            if (n < 2) begin nb[j] = pt[j]; na[j] = pnt[j] <<< 16; end
            else begin na[j] = pt[j]; nb[j] = pnt[j] <<< 16; end
          end
          if (n < 2) begin t2 = t; t1 = (n & 1) ? ONE_Q : '0; end
          else begin t1 = t; t2 = (n & 1) ? ONE_Q : '0; end
        end
      end
    end else begin
      // General position: clamp the line solution with the edge tests
      sn = b * e - c * d;
      tn = a * e - b * d;
      sd = dd;
      td = dd;
      if (sn < 0) begin
        sn = 0; tn = e; td = c;
      end else if (sn > sd) begin
        sn = sd; tn = e + b; td = c;
      end
      if (tn < 0 || tn > td) begin
        k  = (tn < 0) ? -d : b - d;
        tn = (tn < 0) ? 0 : td;
        if (k < 0) sn = 0;
        else if (k > a) sn = sd;
        else begin sn = k; sd = a; end
      end
      t1 = ratio_q(sn, sd);
      t2 = ratio_q(tn, td);
      for (int i = 0; i < 3; i++) begin
        na[i] = (as[i] <<< 16) + $signed({111'd0, t1}) * u[i];
        nb[i] = (bs[i] <<< 16) + $signed({111'd0, t2}) * v[i];
      end
      best = sq_dist(na, nb);
    end
    // Round Q.32 down to Q.16, saturate to the field
    rnd = (best + (128'sd1 <<< 15)) >>> 16;
    r.dist_squared = (rnd > $signed({78'd0, spc_pkg::DIST_MAX})) ? spc_pkg::DIST_MAX
                                                               : rnd[spc_pkg::DIST_W-1:0];
    r.param_a  = t1;
    r.param_b  = t2;
    r.near_a_x = na[0][31:0];
    r.near_a_y = na[1][31:0];
    r.near_a_z = na[2][31:0];
    r.near_b_x = nb[0][31:0];
    r.near_b_y = nb[1][31:0];
    r.near_b_z = nb[2][31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic pair_t mk_pair(int v [12]);
    pair_t p;
    for (int i = 0; i < 12; i++) p.c[i] = v[i][15:0];
    return p;
  endfunction

  function automatic int rnd_in(int lo, int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    mode, lim, kk;
    int    dir [3];
    mode = $urandom_range(0, 9);
    lim  = (mode < 5) ? 8 : 1000;
    for (int i = 0; i < 12; i++) begin
      if (mode < 3) p.c[i] = 16'($urandom());
      else p.c[i] = 16'(rnd_in(-lim, lim));
    end
    case (mode)
      5, 6: begin
        // Parallel or colinear pair
        for (int i = 0; i < 3; i++) dir[i] = rnd_in(-60, 60);
        kk = rnd_in(-3, 3);
        for (int i = 0; i < 3; i++) begin
          p.c[3 + i] = 16'(p.c[i] + dir[i] * rnd_in(-3, 3));
          if (mode == 6) p.c[6 + i] = 16'(p.c[i] + dir[i] * rnd_in(-4, 4));
          p.c[9 + i] = 16'(p.c[6 + i] + dir[i] * kk);
        end
      end
      7: begin
        // Degenerate: one or both segments collapse to a point
        kk = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
          if (kk != 1) p.c[3 + i] = p.c[i];
          if (kk != 0) p.c[9 + i] = p.c[6 + i];
        end
      end
      8: begin
        // Shared endpoint
        for (int i = 0; i < 3; i++) p.c[6 + i] = p.c[3 + i];
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_row(int v [12]);
    stim_t s;
    s.p     = mk_pair(v);
    s.typed = 1'b0;
    s.r     = '0;
    pair_q.push_back(s);
  endtask

  task automatic add_typed(int v [12], closest_t r);
    stim_t s;
    s.p     = mk_pair(v);
    s.typed = 1'b1;
    s.r     = r;
    pair_q.push_back(s);
  endtask

  task automatic build_stimulus();
    closest_t r;
    stim_t    s;
    // Everything at the origin
    add_typed('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, '0);
    // Both segments one shared point
    r = '0;
    r.near_a_x = 327680; r.near_a_y = 327680; r.near_a_z = 327680;
    r.near_b_x = 327680; r.near_b_y = 327680; r.near_b_z = 327680;
    add_typed('{5,5,5, 5,5,5, 5,5,5, 5,5,5}, r);
    // Two separate points, 3-4-5 apart
    r = '0;
    r.near_b_x = 196608; r.near_b_y = 262144;
    r.dist_squared = 50'd25 << 16;
    add_typed('{0,0,0, 0,0,0, 3,4,0, 3,4,0}, r);
    // Points at opposite corners of the coordinate range
    r = '0;
    r.near_a_x = 32'h8000_0000; r.near_a_y = 32'h8000_0000; r.near_a_z = 32'h8000_0000;
    r.near_b_x = 32'h7FFF_0000; r.near_b_y = 32'h7FFF_0000; r.near_b_z = 32'h7FFF_0000;
    r.dist_squared = 50'(64'd12884508675 << 16);
    add_typed('{-32768,-32768,-32768, -32768,-32768,-32768,
                32767,32767,32767, 32767,32767,32767}, r);
    // Crossing skew segments, interior solution
    add_row('{-10,0,0, 10,0,0, 0,-10,5, 0,10,5});
    // Skew, both clamped to ends
    add_row('{0,0,0, 1,0,0, 5,3,2, 5,9,2});
    // Parameter on A below zero, then above one
    add_row('{0,0,0, 4,1,0, -9,-5,3, -9,5,-3});
    add_row('{0,0,0, 4,1,0, 20,-5,3, 20,5,-3});
    // Parameter on B below zero, then above one, with k on both sides
    add_row('{0,0,0, 10,0,0, 5,3,1, 5,9,1});
    add_row('{0,0,0, 10,0,0, 5,-9,1, 5,-3,1});
    add_row('{0,0,0, 10,0,0, -7,3,1, -7,9,1});
    add_row('{0,0,0, 10,0,0, 17,-9,1, 17,-3,1});
    // Parallel: overlapping, disjoint, antiparallel, colinear
    add_row('{0,0,0, 10,0,0, 3,2,0, 13,2,0});
    add_row('{0,0,0, 10,0,0, 20,2,0, 30,2,0});
    add_row('{0,0,0, 10,0,0, 30,2,0, 20,2,0});
    add_row('{0,0,0, 10,0,0, 12,0,0, 15,0,0});
    // Equal candidates, earlier one must win
    add_row('{0,0,0, 4,0,0, 0,1,0, 4,1,0});
    // One segment a point onto the other, with thirds that round
    add_row('{0,0,0, 3,0,0, 1,1,0, 1,1,0});
    add_row('{2,1,0, 2,1,0, 0,0,0, 3,0,0});
    // Full range segments
    add_row('{-32768,-32768,-32768, 32767,32767,32767,
              32767,-32768,32767, -32768,32767,-32768});
    add_row('{-32768,32767,-32768, 32767,-32768,32767,
              -32768,-32768,-32768, 32767,32767,32767});
    for (int i = 0; i < N_RANDOM; i++) begin
      s.p     = rand_pair();
      s.typed = 1'b0;
      s.r     = '0;
      pair_q.push_back(s);
    end
  endtask

  // ---------------------------------------------------------------------
  // Idle pattern: sender 34/receiver 60, then swapped, then none
  // ---------------------------------------------------------------------
  function automatic int idle_phase();
    if (n_accepted < n_total / 3) return 0;
    if (n_accepted < (2 * n_total) / 3) return 1;
    return 2;
  endfunction

  function automatic bit sender_idles();
    case (idle_phase())
      0:       return $urandom_range(0, 99) < 34;
      1:       return $urandom_range(0, 99) < 60;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_phase())
      0:       return $urandom_range(0, 99) < 60;
      1:       return $urandom_range(0, 99) < 34;
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: record the expectation on transfer, hold until taken
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    stim_t s;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        closest_q.push_back(pending_closest);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pair_q.size() > 0 && !sender_idles()) begin
          s = pair_q.pop_front();
          pending_closest = s.typed ? s.r : predict_closest(s.p);
          in_ch.a_start_x <= s.p.c[0];
          in_ch.a_start_y <= s.p.c[1];
          in_ch.a_start_z <= s.p.c[2];
          in_ch.a_end_x   <= s.p.c[3];
          in_ch.a_end_y   <= s.p.c[4];
          in_ch.a_end_z   <= s.p.c[5];
          in_ch.b_start_x <= s.p.c[6];
          in_ch.b_start_y <= s.p.c[7];
          in_ch.b_start_z <= s.p.c[8];
          in_ch.b_end_x   <= s.p.c[9];
          in_ch.b_end_y   <= s.p.c[10];
          in_ch.b_end_z   <= s.p.c[11];
          in_ch.valid     <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output ready
  always @(posedge clk_i) begin
    if (rst_ni) out_ch.ready <= !receiver_stalls();
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %0s: got 0x%0h expected 0x%0h (result %0d)",
             field, got, want, n_accepted);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    closest_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (closest_q.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(out_ch.dist_squared), '0);
      end else begin
        want = closest_q.pop_front();
        if (out_ch.param_a !== want.param_a)
          report_mismatch("param_a", 64'(out_ch.param_a), 64'(want.param_a));
        if (out_ch.param_b !== want.param_b)
          report_mismatch("param_b", 64'(out_ch.param_b), 64'(want.param_b));
        if (out_ch.near_a_x !== want.near_a_x)
          report_mismatch("near_a_x", 64'(out_ch.near_a_x), 64'(want.near_a_x));
        if (out_ch.near_a_y !== want.near_a_y)
          report_mismatch("near_a_y", 64'(out_ch.near_a_y), 64'(want.near_a_y));
        if (out_ch.near_a_z !== want.near_a_z)
          report_mismatch("near_a_z", 64'(out_ch.near_a_z), 64'(want.near_a_z));
        if (out_ch.near_b_x !== want.near_b_x)
          report_mismatch("near_b_x", 64'(out_ch.near_b_x), 64'(want.near_b_x));
        if (out_ch.near_b_y !== want.near_b_y)
          report_mismatch("near_b_y", 64'(out_ch.near_b_y), 64'(want.near_b_y));
        if (out_ch.near_b_z !== want.near_b_z)
          report_mismatch("near_b_z", 64'(out_ch.near_b_z), 64'(want.near_b_z));
        if (out_ch.dist_squared !== want.dist_squared)
          report_mismatch("dist_squared", 64'(out_ch.dist_squared),
                          64'(want.dist_squared));
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, run, drain, verdict
  // ---------------------------------------------------------------------
  initial begin
    n_accepted = 0;
    n_errors   = 0;
    stall_cnt  = 0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.a_start_x = '0; in_ch.a_start_y = '0; in_ch.a_start_z = '0;
    in_ch.a_end_x   = '0; in_ch.a_end_y   = '0; in_ch.a_end_z   = '0;
    in_ch.b_start_x = '0; in_ch.b_start_y = '0; in_ch.b_start_z = '0;
    in_ch.b_end_x   = '0; in_ch.b_end_y   = '0; in_ch.b_end_z   = '0;
    out_ch.ready    = 1'b0;
    build_stimulus();
    n_total = pair_q.size();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pair_q.size() > 0 || in_ch.valid || closest_q.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_errors == 0 && closest_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/spc_pkg.sv
sv/spc_if.sv
sv/spc_front.sv
sv/spc_queue.sv
sv/spc_ratio.sv
sv/spc_back.sv
sv/segment_pair_closest_points.sv
bench/tb_segment_pair_closest_points.sv
